// File: design/lag_trend_predictor_defines.svh
// ============================================================================
// Lag trend predictor assertion macros
// Shared concurrent assertion forms for the checker of the trend predictor.
// ============================================================================
`ifndef LAG_TREND_PREDICTOR_DEFINES_SVH
`define LAG_TREND_PREDICTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LTP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LTP_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ltp_pkg.sv
// ============================================================================
// Lag trend predictor package
// Widths, register indexes, reset values and state codes of the predictor.
// ============================================================================
package ltp_pkg;

    localparam int unsigned HORIZON_DEF    = 4;
    localparam int unsigned SKIP_LIMIT_DEF = 63;

    localparam int unsigned SAMPLE_W   = 15;
    localparam int unsigned GAIN_W     = 9;
    localparam int unsigned LIM_W      = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned VERDICT_W  = 2;
    localparam int unsigned SKIP_W     = 6;
    localparam int unsigned LEVEL_W    = 31;
    localparam int unsigned SLOPE_W    = 32;
    localparam int unsigned MUL_A_W    = 35;
    localparam int unsigned MUL_B_W    = 10;
    localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RISING_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLING_LIMIT   = 3'd4;

    localparam logic [GAIN_W-1:0] GAIN_MIN  = 9'd1;
    localparam logic [GAIN_W-1:0] GAIN_MAX  = 9'd256;
    localparam logic [LIM_W-1:0]  BURST_MIN = 16'd1;

    localparam logic [GAIN_W-1:0] LEVEL_GAIN_RST      = 9'd64;
    localparam logic [GAIN_W-1:0] SLOPE_GAIN_RST      = 9'd32;
    localparam logic [LIM_W-1:0]  BURST_THRESHOLD_RST = 16'd64;
    localparam logic [LIM_W-1:0]  RISING_LIMIT_RST    = 16'd8;
    localparam logic [LIM_W-1:0]  FALLING_LIMIT_RST   = 16'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_SLOPE,
        ST_PROJ,
        ST_HORIZON,
        ST_DONE
    } t_state;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_STABLE  = 2'd0,
        VERDICT_BURST   = 2'd1,
        VERDICT_RISING  = 2'd2,
        VERDICT_FALLING = 2'd3
    } t_trend;

    typedef struct packed {
        logic in_ready;
        logic take;
        logic mul_en;
        logic level_wr;
        logic slope_wr;
        logic out_load;
    } t_ctrl;

endpackage

// File: design/lag_trend_predictor.sv
// ============================================================================
// Lag trend predictor
// Level and slope smoother over lag samples with a projected lag and a
// trend verdict, built around one shared multiplier.
// ============================================================================
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_ready   i_lag_sample
//  result    out        o_out_valid / i_out_ready o_trend_verdict, o_predicted_lag,
//                                                 o_skip_count
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A seeding word goes from ST_IDLE straight to ST_DONE, where results are loaded;
// every later word passes ST_LEVEL, ST_SLOPE, ST_PROJ and ST_HORIZON first, set by
// the three passes through the one multiplier and the slope write between them.
// Reset clears the estimates and restores the register defaults.
// A result waits in the output register; the next word is taken meanwhile and
// holds in its last step until the output register is free.
module lag_trend_predictor #(
    parameter int unsigned HORIZON    = ltp_pkg::HORIZON_DEF,
    parameter int unsigned SKIP_LIMIT = ltp_pkg::SKIP_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [ltp_pkg::SAMPLE_W-1:0]      i_lag_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ltp_pkg::VERDICT_W-1:0]     o_trend_verdict,
    output logic [ltp_pkg::SAMPLE_W-1:0]      o_predicted_lag,
    output logic [ltp_pkg::SKIP_W-1:0]        o_skip_count,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ltp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ltp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    ltp_pkg::t_state r_state, n_state;
    ltp_pkg::t_ctrl  ctrl;

    logic [ltp_pkg::GAIN_W-1:0] r_level_gain, r_slope_gain;
    logic [ltp_pkg::LIM_W-1:0]  r_burst_thr, r_rising_lim, r_falling_lim;
    logic [ltp_pkg::GAIN_W-1:0] cfg_gain;
    logic [ltp_pkg::LIM_W-1:0]  cfg_burst;

    logic [ltp_pkg::SAMPLE_W-1:0]       r_sample, r_prev;
    logic signed [ltp_pkg::SAMPLE_W:0]  r_delta, n_delta;
    logic [ltp_pkg::LEVEL_W-1:0]        r_level, n_level;
    logic signed [ltp_pkg::SLOPE_W-1:0] r_slope, n_slope;
    logic signed [ltp_pkg::PROD_W-1:0]  r_prod, n_prod, prod_shr;
    logic                               r_seeded, r_first;

    logic signed [ltp_pkg::MUL_A_W-1:0] mul_a;
    logic signed [ltp_pkg::MUL_B_W-1:0] mul_b;
    logic signed [32:0]                 lvl_diff;
    logic signed [33:0]                 slope_err;
    logic signed [33:0]                 level_sum;
    logic signed [35:0]                 slope_sum;
    logic signed [38:0]                 proj_sum;

    logic [ltp_pkg::SAMPLE_W-1:0] pred, pred_m1;
    logic [ltp_pkg::SAMPLE_W-1:0] skip_lim;
    logic [ltp_pkg::VERDICT_W-1:0] n_verdict;
    logic [ltp_pkg::SAMPLE_W-1:0] n_pred;
    logic [ltp_pkg::SKIP_W-1:0]   n_skip;

    logic                          r_out_valid;
    logic [ltp_pkg::VERDICT_W-1:0] r_verdict;
    logic [ltp_pkg::SAMPLE_W-1:0]  r_pred;
    logic [ltp_pkg::SKIP_W-1:0]    r_skip;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ltp_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = r_seeded ? ltp_pkg::ST_LEVEL : ltp_pkg::ST_DONE;
                end
            end
            ltp_pkg::ST_LEVEL:   n_state = ltp_pkg::ST_SLOPE;
            ltp_pkg::ST_SLOPE:   n_state = ltp_pkg::ST_PROJ;
            ltp_pkg::ST_PROJ:    n_state = ltp_pkg::ST_HORIZON;
            ltp_pkg::ST_HORIZON: n_state = ltp_pkg::ST_DONE;
            ltp_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ltp_pkg::ST_IDLE;
                end
            end
            default: n_state = ltp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        case (r_state)
            ltp_pkg::ST_IDLE: begin
                ctrl.in_ready = 1'b1;
                ctrl.take     = i_in_valid;
            end
            ltp_pkg::ST_LEVEL: ctrl.mul_en = 1'b1;
            ltp_pkg::ST_SLOPE: begin
                ctrl.mul_en   = 1'b1;
                ctrl.level_wr = 1'b1;
            end
            ltp_pkg::ST_PROJ:    ctrl.slope_wr = 1'b1;
            ltp_pkg::ST_HORIZON: ctrl.mul_en   = 1'b1;
            ltp_pkg::ST_DONE:    ctrl.out_load = !r_out_valid || i_out_ready;
            default: ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ltp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers, with gains and threshold held in range.
    always_comb begin
        cfg_gain = i_cfg_data[ltp_pkg::GAIN_W-1:0];
        if (cfg_gain == '0) begin
            cfg_gain = ltp_pkg::GAIN_MIN;
        end else if (cfg_gain > ltp_pkg::GAIN_MAX) begin
            cfg_gain = ltp_pkg::GAIN_MAX;
        end
        cfg_burst = (i_cfg_data == '0) ? ltp_pkg::BURST_MIN : i_cfg_data;
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_gain  <= ltp_pkg::LEVEL_GAIN_RST;
            r_slope_gain  <= ltp_pkg::SLOPE_GAIN_RST;
            r_burst_thr   <= ltp_pkg::BURST_THRESHOLD_RST;
            r_rising_lim  <= ltp_pkg::RISING_LIMIT_RST;
            r_falling_lim <= ltp_pkg::FALLING_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ltp_pkg::CFG_LEVEL_GAIN:      r_level_gain  <= cfg_gain;
                ltp_pkg::CFG_SLOPE_GAIN:      r_slope_gain  <= cfg_gain;
                ltp_pkg::CFG_BURST_THRESHOLD: r_burst_thr   <= cfg_burst;
                ltp_pkg::CFG_RISING_LIMIT:    r_rising_lim  <= i_cfg_data;
                ltp_pkg::CFG_FALLING_LIMIT:   r_falling_lim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Shared multiplier and its operand selection.
    assign lvl_diff  = $signed({2'b00, r_sample, 16'h0000}) - $signed({2'b00, r_level});
    assign slope_err = $signed({{2{r_delta[ltp_pkg::SAMPLE_W]}}, r_delta, 16'h0000})
                     - $signed({{2{r_slope[ltp_pkg::SLOPE_W-1]}}, r_slope});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ltp_pkg::ST_LEVEL: begin
                mul_a = {{2{lvl_diff[32]}}, lvl_diff};
                mul_b = $signed({1'b0, r_level_gain});
            end
            ltp_pkg::ST_SLOPE: begin
                mul_a = {slope_err[33], slope_err};
                mul_b = $signed({1'b0, r_slope_gain});
            end
            ltp_pkg::ST_HORIZON: begin
                mul_a = {{3{r_slope[ltp_pkg::SLOPE_W-1]}}, r_slope};
                mul_b = $signed(ltp_pkg::MUL_B_W'(HORIZON));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        n_prod = mul_a * mul_b;
    end

    // Floor division by 256, then the clamped level and slope updates.
    assign prod_shr  = r_prod >>> 8;
    assign level_sum = $signed({3'b000, r_level}) + $signed(prod_shr[33:0]);
    assign slope_sum = $signed({{4{r_slope[ltp_pkg::SLOPE_W-1]}}, r_slope})
                     + $signed(prod_shr[35:0]);
    assign n_delta   = $signed({1'b0, r_sample}) - $signed({1'b0, r_prev});

    always_comb begin
        if (level_sum[33]) begin
            n_level = '0;
        end else if (level_sum[32:31] != 2'b00) begin
            n_level = {ltp_pkg::LEVEL_W{1'b1}};
        end else begin
            n_level = level_sum[30:0];
        end

        if (slope_sum[35:31] == 5'b00000 || slope_sum[35:31] == 5'b11111) begin
            n_slope = slope_sum[31:0];
        end else if (slope_sum[35]) begin
            n_slope = {1'b1, {(ltp_pkg::SLOPE_W-1){1'b0}}};
        end else begin
            n_slope = {1'b0, {(ltp_pkg::SLOPE_W-1){1'b1}}};
        end
    end

    // Projection and verdict.
    assign proj_sum = $signed({8'h00, r_level}) + $signed(r_prod[38:0]);
    assign skip_lim = ltp_pkg::SAMPLE_W'(SKIP_LIMIT);
    assign pred_m1  = (pred == '0) ? '0 : pred - 1'b1;

    always_comb begin
        if (proj_sum[38]) begin
            pred = '0;
        end else if (proj_sum[37:31] != 7'h00) begin
            pred = {ltp_pkg::SAMPLE_W{1'b1}};
        end else begin
            pred = proj_sum[30:16];
        end

        n_verdict = ltp_pkg::VERDICT_STABLE;
        n_pred    = pred;
        n_skip    = '0;
        if (r_first) begin
            n_pred = r_sample;
        end else if (!r_delta[ltp_pkg::SAMPLE_W] && $unsigned(r_delta) >= r_burst_thr) begin
            n_verdict = ltp_pkg::VERDICT_BURST;
            n_skip    = (pred > skip_lim) ? skip_lim[ltp_pkg::SKIP_W-1:0]
                                          : pred[ltp_pkg::SKIP_W-1:0];
            if (pred == '0) begin
                n_skip = ltp_pkg::SKIP_W'(1);
            end
        end else if ({1'b0, pred} >= r_rising_lim && r_slope >= 32'sd32768) begin
            n_verdict = ltp_pkg::VERDICT_RISING;
            n_skip    = (pred_m1 > skip_lim) ? skip_lim[ltp_pkg::SKIP_W-1:0]
                                             : pred_m1[ltp_pkg::SKIP_W-1:0];
        end else if ({1'b0, pred} <= r_falling_lim && r_slope <= -32'sd32768) begin
            n_verdict = ltp_pkg::VERDICT_FALLING;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= 1'b0;
            r_first  <= 1'b0;
            r_level  <= '0;
            r_slope  <= '0;
            r_prev   <= '0;
        end else begin
            if (ctrl.take) begin
                r_first <= !r_seeded;
                if (!r_seeded) begin
                    r_seeded <= 1'b1;
                    r_level  <= {i_lag_sample, 16'h0000};
                    r_slope  <= '0;
                    r_prev   <= i_lag_sample;
                end
            end
            if (r_state == ltp_pkg::ST_LEVEL) begin
                r_prev <= r_sample;
            end
            if (ctrl.level_wr) begin
                r_level <= n_level;
            end
            if (ctrl.slope_wr) begin
                r_slope <= n_slope;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.take) begin
            r_sample <= i_lag_sample;
        end
        if (r_state == ltp_pkg::ST_LEVEL) begin
            r_delta <= n_delta;
        end
        if (ctrl.mul_en) begin
            r_prod <= n_prod;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_verdict <= n_verdict;
            r_pred    <= n_pred;
            r_skip    <= n_skip;
        end
    end

    assign o_in_ready      = ctrl.in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_trend_verdict = r_verdict;
    assign o_predicted_lag = r_pred;
    assign o_skip_count    = r_skip;

endmodule

// File: design/ltp_checker.sv
// ============================================================================
// Lag trend predictor checker
// Port-level assertions on the predictor, attached to the predictor module by bind.
// ============================================================================
`include "lag_trend_predictor_defines.svh"

module ltp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [ltp_pkg::VERDICT_W-1:0] i_verdict,
    input logic [ltp_pkg::SAMPLE_W-1:0]  i_pred,
    input logic [ltp_pkg::SKIP_W-1:0]    i_skip
);

    // The block works on one word at a time once it has taken one.
    `LTP_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "ready stayed high after a word was taken")

    `LTP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_pred) && $stable(i_skip) && $stable(i_verdict), "stalled result changed")

    `LTP_ASSERT_IMP(a_skip_zero, i_clk, i_rst_n, i_out_valid && (i_verdict == ltp_pkg::VERDICT_STABLE || i_verdict == ltp_pkg::VERDICT_FALLING), i_skip == '0, "skip count set on a stable or falling verdict")

    `LTP_ASSERT_IMP(a_burst_skip, i_clk, i_rst_n, i_out_valid && i_verdict == ltp_pkg::VERDICT_BURST, i_skip != '0, "burst verdict without a skip count")

endmodule

bind lag_trend_predictor ltp_checker u_ltp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_verdict   (o_trend_verdict),
    .i_pred      (o_predicted_lag),
    .i_skip      (o_skip_count)
);

// File: tb/sv/lag_trend_checker.sv
// ----------------------------------------------------------------------------
// Lag trend predictor checker
// Watches the sample, result and register channels of the predictor, keeps
// its own level, slope and register state, works out the verdict, projected
// lag and skip count for every accepted sample word, and compares each
// accepted result word with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lag_trend_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [ltp_pkg::SAMPLE_W-1:0]    i_lag_sample,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [ltp_pkg::VERDICT_W-1:0]   i_trend_verdict,
    input  logic [ltp_pkg::SAMPLE_W-1:0]    i_predicted_lag,
    input  logic [ltp_pkg::SKIP_W-1:0]      i_skip_count,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [ltp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ltp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import ltp_pkg::*;

    localparam longint Q16_MAX   = 64'sd2147483647;
    localparam longint SLOPE_MIN = -64'sd2147483648;
    localparam longint HALF_STEP = 64'sd32768;

    typedef struct packed {
        t_trend                verdict;
        logic [SAMPLE_W-1:0]   lag;
        logic [SKIP_W-1:0]     skip;
    } trend_result_t;

    logic [GAIN_W-1:0]         level_gain_q;
    logic [GAIN_W-1:0]         slope_gain_q;
    logic [LIM_W-1:0]          burst_q;
    logic [LIM_W-1:0]          rising_q;
    logic [LIM_W-1:0]          falling_q;
    logic [LEVEL_W-1:0]        level_q;
    logic signed [SLOPE_W-1:0] slope_q;
    logic [SAMPLE_W-1:0]       last_sample_q;
    logic                      seeded_q;
    trend_result_t             expected_trends[$];

    function automatic logic [GAIN_W-1:0] limit_gain(input logic [GAIN_W-1:0] g);
        if (g < GAIN_MIN) begin
            return GAIN_MIN;
        end
        if (g > GAIN_MAX) begin
            return GAIN_MAX;
        end
        return g;
    endfunction

    function automatic trend_result_t predict_trend(input logic [SAMPLE_W-1:0] sample);
        trend_result_t r;
        longint        s;
        longint        delta;
        longint        lvl;
        longint        slp;
        longint        proj;
        longint        lag;
        longint        skip;
        r.verdict = VERDICT_STABLE;
        r.lag     = sample;
        r.skip    = '0;
        if (!seeded_q) begin
            level_q       = {sample, 16'd0};
            slope_q       = '0;
            last_sample_q = sample;
            seeded_q      = 1'b1;
            return r;
        end
        s             = longint'(sample);
        delta         = s - longint'(last_sample_q);
        last_sample_q = sample;

        // Both smoothing steps divide by 256 rounding toward minus infinity.
        lvl = longint'(level_q);
        lvl = lvl + ((longint'(level_gain_q) * ((s <<< 16) - lvl)) >>> 8);
        if (lvl < 0) begin
            lvl = 0;
        end
        if (lvl > Q16_MAX) begin
            lvl = Q16_MAX;
        end
        level_q = LEVEL_W'(lvl);

        slp = longint'(slope_q);
        slp = slp + ((longint'(slope_gain_q) * ((delta <<< 16) - slp)) >>> 8);
        if (slp > Q16_MAX) begin
            slp = Q16_MAX;
        end
        if (slp < SLOPE_MIN) begin
            slp = SLOPE_MIN;
        end
        slope_q = SLOPE_W'(slp);

        proj = lvl + slp * longint'(HORIZON_DEF);
        if (proj < 0) begin
            proj = 0;
        end
        if (proj > Q16_MAX) begin
            proj = Q16_MAX;
        end
        lag   = proj >>> 16;
        r.lag = SAMPLE_W'(lag);

        if (delta >= 0 && delta >= longint'(burst_q)) begin
            skip = (lag > longint'(SKIP_LIMIT_DEF)) ? longint'(SKIP_LIMIT_DEF) : lag;
            if (skip == 0) begin
                skip = 1;
            end
            r.verdict = VERDICT_BURST;
            r.skip    = SKIP_W'(skip);
        end else if (lag >= longint'(rising_q) && slp >= HALF_STEP) begin
            skip = (lag >= 1) ? lag - 1 : 0;
            if (skip > longint'(SKIP_LIMIT_DEF)) begin
                skip = longint'(SKIP_LIMIT_DEF);
            end
            r.verdict = VERDICT_RISING;
            r.skip    = SKIP_W'(skip);
        end else if (lag <= longint'(falling_q) && slp <= -HALF_STEP) begin
            r.verdict = VERDICT_FALLING;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        trend_result_t want;
        if (!i_rst_n) begin
            level_gain_q  = LEVEL_GAIN_RST;
            slope_gain_q  = SLOPE_GAIN_RST;
            burst_q       = BURST_THRESHOLD_RST;
            rising_q      = RISING_LIMIT_RST;
            falling_q     = FALLING_LIMIT_RST;
            level_q       = '0;
            slope_q       = '0;
            last_sample_q = '0;
            seeded_q      = 1'b0;
            expected_trends.delete();
            o_fail_count  <= 0;
            o_outstanding <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_trends.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("[%0t] result word with no sample outstanding: verdict %0d lag %0d skip %0d",
                                 $time, i_trend_verdict, i_predicted_lag, i_skip_count);
                    end
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_trends.pop_front();
                    if (i_trend_verdict != want.verdict || i_predicted_lag != want.lag ||
                        i_skip_count != want.skip) begin
                        if (o_fail_count < 10) begin
                            $display("[%0t] result mismatch: expected verdict %0d lag %0d skip %0d",
                                     $time, want.verdict, want.lag, want.skip);
                            $display("[%0t]                  got      verdict %0d lag %0d skip %0d",
                                     $time, i_trend_verdict, i_predicted_lag, i_skip_count);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_trends.push_back(predict_trend(i_lag_sample));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LEVEL_GAIN: begin
                        level_gain_q = limit_gain(i_cfg_data[GAIN_W-1:0]);
                    end
                    CFG_SLOPE_GAIN: begin
                        slope_gain_q = limit_gain(i_cfg_data[GAIN_W-1:0]);
                    end
                    CFG_BURST_THRESHOLD: begin
                        burst_q = (i_cfg_data == '0) ? BURST_MIN : i_cfg_data;
                    end
                    CFG_RISING_LIMIT: begin
                        rising_q = i_cfg_data;
                    end
                    CFG_FALLING_LIMIT: begin
                        falling_q = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            o_outstanding <= expected_trends.size();
        end
    end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Lag trend predictor testbench
// Drives lag sample words and register writes into the predictor with random
// gaps and result back-pressure, including one long result stall that fills
// the block. A short directed run covers seeding, extreme samples and
// out-of-range register values; random phases of ramps, decays, jitter,
// jumps and noise follow under varied register settings.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ltp_pkg::*;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_in_valid   = 1'b0;
    logic                   o_in_ready;
    logic [SAMPLE_W-1:0]    i_lag_sample = '0;
    logic                   o_out_valid;
    logic                   i_out_ready  = 1'b0;
    logic [VERDICT_W-1:0]   o_trend_verdict;
    logic [SAMPLE_W-1:0]    o_predicted_lag;
    logic [SKIP_W-1:0]      o_skip_count;
    logic                   i_cfg_valid  = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data   = '0;

    int fail_count;
    int outstanding;
    bit calm = 1'b0;

    always #1 i_clk = ~i_clk;

    lag_trend_predictor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_lag_sample    (i_lag_sample),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_trend_verdict (o_trend_verdict),
        .o_predicted_lag (o_predicted_lag),
        .o_skip_count    (o_skip_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    lag_trend_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_lag_sample    (i_lag_sample),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_trend_verdict (o_trend_verdict),
        .i_predicted_lag (o_predicted_lag),
        .i_skip_count    (o_skip_count),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
        while (!calm && $urandom_range(99) < 28) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_lag_sample <= sample;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // The write to an unused index comes last so that any aliasing shows up.
    task automatic set_config(input logic [CFG_DATA_W-1:0] level_gain,
                              input logic [CFG_DATA_W-1:0] slope_gain,
                              input logic [CFG_DATA_W-1:0] burst,
                              input logic [CFG_DATA_W-1:0] rise,
                              input logic [CFG_DATA_W-1:0] fall);
        write_reg(CFG_LEVEL_GAIN, level_gain);
        write_reg(CFG_SLOPE_GAIN, slope_gain);
        write_reg(CFG_BURST_THRESHOLD, burst);
        write_reg(CFG_RISING_LIMIT, rise);
        write_reg(CFG_FALLING_LIMIT, fall);
        write_reg(CFG_FALLING_LIMIT + CFG_IDX_W'($urandom_range(3, 1)),
                  CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        logic [GAIN_W-1:0] g;
        case ($urandom_range(5))
            0:       g = '0;
            1:       g = GAIN_MIN;
            2:       g = GAIN_MAX;
            3:       g = '1;
            default: g = GAIN_W'($urandom_range(256, 1));
        endcase
        return {(CFG_DATA_W - GAIN_W)'($urandom), g};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_bound();
        case ($urandom_range(6))
            0:       return '0;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3:       return '1;
            4:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(64));
        endcase
    endfunction

    // Mostly shaped lag traces so that trends build up in the estimates.
    task automatic run_random(input int count);
        int cur;
        int step;
        int len;
        int mode;
        cur = int'($urandom_range(32767));
        while (count > 0) begin
            mode = int'($urandom_range(7));
            len  = int'($urandom_range(30, 4));
            step = int'($urandom_range(60)) - 30;
            if ($urandom_range(3) == 0) begin
                step = step * 50;
            end
            for (int k = 0; k < len && count > 0; k++) begin
                case (mode)
                    0, 1:    cur = cur + step;
                    2:       cur = cur - int'($urandom_range(40));
                    3:       cur = cur + int'($urandom_range(16)) - 8;
                    4:       cur = (k == len - 1) ? int'($urandom_range(32767))
                                                  : cur + int'($urandom_range(4)) - 2;
                    5:       cur = int'($urandom_range(32767));
                    6:       cur = int'($urandom_range(24));
                    default: cur = 32767 - int'($urandom_range(64));
                endcase
                if (cur < 0) begin
                    cur = 0;
                end
                if (cur > 32767) begin
                    cur = 32767;
                end
                send_sample(SAMPLE_W'(cur));
                count--;
            end
        end
    endtask

    initial begin : result_sink
        int taken;
        bit held;
        taken = 0;
        held  = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                taken++;
            end
            if (taken == 600 && !held) begin
                held = 1'b1;
                repeat (400) begin
                    i_out_ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            i_out_ready <= calm || ($urandom_range(99) >= 28);
        end
    end

    initial begin : stimulus
        int unsigned trace_defaults[16] = '{0, 32767, 32767, 0, 0, 0, 10, 20, 30, 40,
                                           50, 40, 30, 20, 10, 0};
        int unsigned trace_clamped[5]   = '{5, 6, 32767, 16384, 1};
        int unsigned trace_sharp[4]     = '{16384, 0, 21845, 10922};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first word seeds the estimates under the reset register values.
        foreach (trace_defaults[n]) begin
            send_sample(SAMPLE_W'(trace_defaults[n]));
        end
        wait_idle();
        set_config(16'hFE00, 16'h01FF, 16'h0000, 16'hFFFF, 16'h7FFF);
        foreach (trace_clamped[n]) begin
            send_sample(SAMPLE_W'(trace_clamped[n]));
        end
        wait_idle();
        set_config(16'd256, 16'd1, 16'h8000, 16'h0000, 16'h0000);
        foreach (trace_sharp[n]) begin
            send_sample(SAMPLE_W'(trace_sharp[n]));
        end

        for (int p = 0; p < 8; p++) begin
            wait_idle();
            set_config(pick_gain(), pick_gain(), pick_bound(), pick_bound(), pick_bound());
            calm = (p == 3);
            run_random(250);
        end
        calm = 1'b0;

        wait_idle();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/ltp_pkg.sv
design/lag_trend_predictor.sv
design/ltp_checker.sv
tb/sv/lag_trend_checker.sv
tb/sv/tb_top.sv
